FILE: rtl/bcdtod_pkg.sv
`default_nettype none

package bcdtod_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register selects.
    localparam logic [2:0] SEL_TENTHS  = 3'd0;
    localparam logic [2:0] SEL_SECONDS = 3'd1;
    localparam logic [2:0] SEL_MINUTES = 3'd2;
    localparam logic [2:0] SEL_HOURS   = 3'd3;
    localparam logic [2:0] SEL_ICR     = 3'd4;

    // Configuration register file.
    localparam int          PADDR_W          = 3;
    localparam int          PRESCALE_W       = 20;
    localparam logic [19:0] PRESCALE_RESET   = 20'd99999;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic       write_to_alarm;
        logic       timer_a_underflow;
        logic       timer_b_underflow;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
    } out_item_t;

    // Controls from the top level to the time-of-day counters.
    typedef struct packed {
        logic       tick;
        logic       write_time;
        logic       write_alarm;
        logic [2:0] sel;
    } tod_ctrl_t;

    // Current time as seen on register reads.
    typedef struct packed {
        logic [3:0] tenths;
        logic [6:0] seconds;
        logic [6:0] minutes;
        logic [7:0] hours;
    } tod_time_t;

    // Controls from the top level to the interrupt controller.
    typedef struct packed {
        logic tick;
        logic timer_a;
        logic timer_b;
        logic alarm_hit;
        logic read_icr;
        logic write_icr;
    } irq_ctrl_t;

    // Binary value of a BCD digit pair; the digits may hold non-decimal codes.
    function automatic logic [7:0] pair_to_binary(input logic [3:0] tens, input logic [3:0] units);
        return {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'b0000, units};
    endfunction

    // BCD form of a value below 60.
    function automatic logic [6:0] binary_to_pair(input logic [5:0] v);
        logic [2:0] tens;
        logic [5:0] rest;
        if (v >= 6'd50) begin
            tens = 3'd5;
            rest = v - 6'd50;
        end else if (v >= 6'd40) begin
            tens = 3'd4;
            rest = v - 6'd40;
        end else if (v >= 6'd30) begin
            tens = 3'd3;
            rest = v - 6'd30;
        end else if (v >= 6'd20) begin
            tens = 3'd2;
            rest = v - 6'd20;
        end else if (v >= 6'd10) begin
            tens = 3'd1;
            rest = v - 6'd10;
        end else begin
            tens = 3'd0;
            rest = v;
        end
        return {tens, rest[3:0]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bcdtod_time.sv
`default_nettype none

module bcdtod_time
    import bcdtod_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire tod_ctrl_t             ctrl,
    input  wire logic [7:0]            wdata,
    input  wire logic [PRESCALE_W-1:0] reload,
    output tod_time_t                  cur_time,
    output logic                       alarm_hit
);

    logic [3:0]            tenths_reg, tenths_next;
    logic [6:0]            seconds_reg, seconds_next;
    logic [6:0]            minutes_reg, minutes_next;
    logic [7:0]            hours_reg, hours_next;
    logic [3:0]            al_tenths_reg, al_tenths_next;
    logic [6:0]            al_seconds_reg, al_seconds_next;
    logic [6:0]            al_minutes_reg, al_minutes_next;
    logic [7:0]            al_hours_reg, al_hours_next;
    logic [PRESCALE_W-1:0] prescale_reg, prescale_next;

    logic [7:0] sec_sum;
    logic [7:0] min_sum;
    logic [7:0] hour_sum;
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [7:0] hour_inc;
    logic [6:0] hour_bcd_am;
    logic [6:0] hour_bcd_pm;
    logic [7:0] hour_less12;

    // One-second, one-minute and one-hour increments of the present time.
    always_comb begin
        sec_sum  = pair_to_binary({1'b0, seconds_reg[6:4]}, seconds_reg[3:0]) + 8'd1;
        min_sum  = pair_to_binary({1'b0, minutes_reg[6:4]}, minutes_reg[3:0]) + 8'd1;
        hour_sum = pair_to_binary({3'b000, hours_reg[4]}, hours_reg[3:0])
                   + (hours_reg[7] ? 8'd12 : 8'd0) + 8'd1;
        sec_inc  = (sec_sum >= 8'd60) ? 7'd0 : binary_to_pair(sec_sum[5:0]);
        min_inc  = (min_sum >= 8'd60) ? 7'd0 : binary_to_pair(min_sum[5:0]);
        hour_less12 = hour_sum - 8'd12;
        hour_bcd_am = binary_to_pair(hour_sum[5:0]);
        hour_bcd_pm = binary_to_pair(hour_less12[5:0]);
        if (hour_sum >= 8'd24) begin
            hour_inc = 8'd0;
        end else if (hour_sum >= 8'd12) begin
            hour_inc = {1'b1, 2'b00, hour_bcd_pm[4:0]};
        end else begin
            hour_inc = {3'b000, hour_bcd_am[4:0]};
        end
    end

    always_comb begin
        tenths_next     = tenths_reg;
        seconds_next    = seconds_reg;
        minutes_next    = minutes_reg;
        hours_next      = hours_reg;
        al_tenths_next  = al_tenths_reg;
        al_seconds_next = al_seconds_reg;
        al_minutes_next = al_minutes_reg;
        al_hours_next   = al_hours_reg;
        prescale_next   = prescale_reg;

        if (ctrl.tick) begin
            if (prescale_reg == '0) begin
                prescale_next = reload;
                if (tenths_reg < 4'd9) begin
                    tenths_next = tenths_reg + 4'd1;
                end else begin
                    tenths_next  = 4'd0;
                    seconds_next = sec_inc;
                    if (sec_sum >= 8'd60) begin
                        minutes_next = min_inc;
                        if (min_sum >= 8'd60) begin
                            hours_next = hour_inc;
                        end
                    end
                end
            end else begin
                prescale_next = prescale_reg - PRESCALE_W'(1);
            end
        end

        if (ctrl.write_time) begin
            case (ctrl.sel)
                SEL_TENTHS:  tenths_next  = wdata[3:0];
                SEL_SECONDS: seconds_next = wdata[6:0];
                SEL_MINUTES: minutes_next = wdata[6:0];
                SEL_HOURS:   hours_next   = {wdata[7], 2'b00, wdata[4:0]};
                default: ;
            endcase
        end

        if (ctrl.write_alarm) begin
            case (ctrl.sel)
                SEL_TENTHS:  al_tenths_next  = wdata[3:0];
                SEL_SECONDS: al_seconds_next = wdata[6:0];
                SEL_MINUTES: al_minutes_next = wdata[6:0];
                SEL_HOURS:   al_hours_next   = {wdata[7], 2'b00, wdata[4:0]};
                default: ;
            endcase
        end
    end

    // The alarm compares against the time as it stands after this tick.
    assign alarm_hit = (tenths_next == al_tenths_reg) && (seconds_next == al_seconds_reg) &&
                       (minutes_next == al_minutes_reg) && (hours_next == al_hours_reg);

    assign cur_time = '{tenths: tenths_reg, seconds: seconds_reg,
                        minutes: minutes_reg, hours: hours_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tenths_reg     <= '0;
            seconds_reg    <= '0;
            minutes_reg    <= '0;
            hours_reg      <= '0;
            al_tenths_reg  <= '0;
            al_seconds_reg <= '0;
            al_minutes_reg <= '0;
            al_hours_reg   <= '0;
            prescale_reg   <= '0;
        end else begin
            tenths_reg     <= tenths_next;
            seconds_reg    <= seconds_next;
            minutes_reg    <= minutes_next;
            hours_reg      <= hours_next;
            al_tenths_reg  <= al_tenths_next;
            al_seconds_reg <= al_seconds_next;
            al_minutes_reg <= al_minutes_next;
            al_hours_reg   <= al_hours_next;
            prescale_reg   <= prescale_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bcdtod_irq.sv
`default_nettype none

module bcdtod_irq
    import bcdtod_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire irq_ctrl_t  ctrl,
    input  wire logic [7:0] wdata,
    output logic [7:0]      icr_value,
    output logic            irq_next
);

    logic [2:0] flags_reg, flags_next;
    logic       ir_reg, ir_next;
    logic [6:0] mask_reg, mask_next;
    logic [2:0] flags_set;

    always_comb begin
        flags_set  = flags_reg | {ctrl.alarm_hit, ctrl.timer_b, ctrl.timer_a};
        flags_next = flags_reg;
        ir_next    = ir_reg;
        mask_next  = mask_reg;
        if (ctrl.tick) begin
            flags_next = flags_set;
            if (!ir_reg && ((flags_set & mask_reg[2:0]) != 3'b000)) begin
                ir_next = 1'b1;
            end
        end
        if (ctrl.read_icr) begin
            flags_next = '0;
            ir_next    = 1'b0;
        end
        if (ctrl.write_icr) begin
            if (wdata[7]) begin
                mask_next = mask_reg | wdata[6:0];
            end else begin
                mask_next = mask_reg & ~wdata[6:0];
            end
        end
    end

    // The request line follows the IR bit exactly.
    assign icr_value = {ir_reg, 4'b0000, flags_reg};
    assign irq_next  = ir_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
            ir_reg    <= 1'b0;
            mask_reg  <= '0;
        end else begin
            flags_reg <= flags_next;
            ir_reg    <= ir_next;
            mask_reg  <= mask_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bcd_tod_clock_alarm_interrupt.sv
`default_nettype none

// Time-of-day clock with alarm and a small interrupt controller. Every input
// transfer is a clock tick, a register read, a register write or a spare
// code, and each one produces exactly one result transfer carrying read data
// (zero but for reads) and the interrupt request level after the item. A tick
// counts the prescaler down; when the prescaler is found at zero it reloads
// from cycles_per_tenth (APB address 0) and the clock advances one tenth of
// a second in BCD with 12-hour hours and a PM flag. Each tick also compares the
// time with the alarm and latches the timer A and B underflow bits into the
// flags; a flag enabled in the mask raises IRQ, and reading the interrupt
// control register returns the flags, clears them and drops IRQ. The block
// takes one item per clock cycle while the result side is ready: an item
// waits in the input register, and when it advances the state and the
// result register are updated at the same edge, so the result of an item
// is registered ahead of its transfer on the result channel. A result that
// is not taken holds the item behind it in the input register, which stalls
// the input channel. The update of the time, alarm compare and flag logic
// is the single combinational stage.
// cycles_per_tenth must only be changed while no items are in flight.

module bcd_tod_clock_alarm_interrupt
    import bcdtod_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_item_t           s_data,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_item_t               m_data,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // Input register stage.
    logic     in_valid_reg, in_valid_next;
    in_item_t in_data_reg, in_data_next;

    // Result register stage.
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic [PRESCALE_W-1:0] reload_reg, reload_next;

    logic      advance;
    tod_ctrl_t tod_ctrl;
    irq_ctrl_t irq_ctrl;
    tod_time_t cur_time;
    logic      alarm_hit;
    logic [7:0] icr_value;
    logic      irq_next;
    logic [7:0] rdata;
    logic      is_tick;
    logic      is_read;
    logic      is_write;

    // The item in the input register is processed when the result register
    // is free or is being emptied in the same cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign is_tick  = advance && (in_data_reg.operation == OP_TICK);
    assign is_read  = advance && (in_data_reg.operation == OP_READ);
    assign is_write = advance && (in_data_reg.operation == OP_WRITE);

    always_comb begin
        tod_ctrl.tick        = is_tick;
        tod_ctrl.write_time  = is_write && !in_data_reg.write_to_alarm &&
                               (in_data_reg.reg_select < SEL_ICR);
        tod_ctrl.write_alarm = is_write && in_data_reg.write_to_alarm &&
                               (in_data_reg.reg_select < SEL_ICR);
        tod_ctrl.sel         = in_data_reg.reg_select;

        irq_ctrl.tick      = is_tick;
        irq_ctrl.timer_a   = in_data_reg.timer_a_underflow;
        irq_ctrl.timer_b   = in_data_reg.timer_b_underflow;
        irq_ctrl.alarm_hit = alarm_hit;
        irq_ctrl.read_icr  = is_read && (in_data_reg.reg_select == SEL_ICR);
        irq_ctrl.write_icr = is_write && (in_data_reg.reg_select == SEL_ICR);
    end

    bcdtod_time u_time (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (tod_ctrl),
        .wdata     (in_data_reg.write_data),
        .reload    (reload_reg),
        .cur_time  (cur_time),
        .alarm_hit (alarm_hit)
    );

    bcdtod_irq u_irq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (irq_ctrl),
        .wdata     (in_data_reg.write_data),
        .icr_value (icr_value),
        .irq_next  (irq_next)
    );

    // Read data comes from the registers as they stand before the item.
    always_comb begin
        rdata = 8'd0;
        if (in_data_reg.operation == OP_READ) begin
            case (in_data_reg.reg_select)
                SEL_TENTHS:  rdata = {4'b0000, cur_time.tenths};
                SEL_SECONDS: rdata = {1'b0, cur_time.seconds};
                SEL_MINUTES: rdata = {1'b0, cur_time.minutes};
                SEL_HOURS:   rdata = cur_time.hours;
                SEL_ICR:     rdata = icr_value;
                default:     rdata = 8'd0;
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_data_next  = s_data;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance) begin
            out_valid_next          = 1'b1;
            out_data_next.read_data = rdata;
            out_data_next.irq       = irq_next;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration port: a single register, decoded on address bit 2 being clear.
    always_comb begin
        reload_next = reload_reg;
        if (psel && penable && pwrite && pready && !paddr[2]) begin
            reload_next = pwdata[PRESCALE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-PRESCALE_W){1'b0}}, reload_reg};

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            reload_reg    <= PRESCALE_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            reload_reg    <= reload_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: sim/tod_checker.sv
`timescale 1ns / 100ps

// Watches both item channels and the APB port of the time-of-day clock, keeps
// its own copy of the clock, alarm and interrupt state, and compares every
// result transfer against the oldest outstanding prediction.
module tod_checker
    import bcdtod_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  in_item_t           s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  out_item_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 fail_count,
    output int                 pending,
    output int                 tick_count,
    output int                 read_count,
    output int                 write_count,
    output int                 alarm_hits,
    output int                 irq_raises
);

    localparam logic [PADDR_W-1:0] ADDR_RELOAD = '0;

    localparam logic [7:0] FLG_TIMER_A = 8'h01;
    localparam logic [7:0] FLG_TIMER_B = 8'h02;
    localparam logic [7:0] FLG_ALARM   = 8'h04;
    localparam logic [7:0] FLG_IR      = 8'h80;

    logic [19:0] reload_q;
    logic [19:0] presc_q;
    logic [7:0]  tenths_q;
    logic [7:0]  sec_q;
    logic [7:0]  min_q;
    logic [7:0]  hour_q;
    logic [7:0]  alarm_q [4];
    logic [7:0]  flags_q;
    logic [6:0]  mask_q;
    logic        irq_q;

    out_item_t   due_outputs [$];
    int          mismatches = 0;
    int          ticks = 0, reads = 0, writes = 0, hits = 0, raises = 0;

    function automatic int pair_value(input logic [7:0] v);
        return int'(v[7:4]) * 10 + int'(v[3:0]);
    endfunction

    function automatic logic [7:0] as_bcd(input int v);
        logic [7:0] r;
        r[7:4] = 4'(v / 10);
        r[3:0] = 4'(v % 10);
        return r;
    endfunction

    // One tenth of a second; out-of-range digit pairs wrap as soon as they
    // reach their limit.
    task automatic step_tenth();
        int s, m, h;
        if (tenths_q < 8'd9) begin
            tenths_q = tenths_q + 8'd1;
            return;
        end
        tenths_q = '0;
        s = pair_value(sec_q) + 1;
        if (s >= 60) begin
            s = 0;
            m = pair_value(min_q) + 1;
            if (m >= 60) begin
                m = 0;
                h = pair_value(hour_q & 8'h1F) + (hour_q[7] ? 12 : 0) + 1;
                if (h >= 24) begin
                    hour_q = '0;
                end else if (h >= 12) begin
                    hour_q = as_bcd(h - 12) | 8'h80;
                end else begin
                    hour_q = as_bcd(h);
                end
            end
            min_q = as_bcd(m);
        end
        sec_q = as_bcd(s);
    endtask

    task automatic apply_tod_item(input in_item_t it, output out_item_t res);
        logic [7:0] rd;
        logic [7:0] keep;
        rd = '0;
        case (it.operation)
            OP_TICK: begin
                ticks++;
                if (it.timer_a_underflow) flags_q |= FLG_TIMER_A;
                if (it.timer_b_underflow) flags_q |= FLG_TIMER_B;
                if (presc_q == '0) begin
                    step_tenth();
                    presc_q = reload_q;
                end else begin
                    presc_q = presc_q - 20'd1;
                end
                if (tenths_q == alarm_q[0] && sec_q == alarm_q[1] &&
                    min_q == alarm_q[2] && hour_q == alarm_q[3]) begin
                    flags_q |= FLG_ALARM;
                    hits++;
                end
                if (!flags_q[7] && (flags_q[6:0] & mask_q) != '0) begin
                    flags_q |= FLG_IR;
                    irq_q = 1'b1;
                    raises++;
                end
            end
            OP_READ: begin
                reads++;
                case (it.reg_select)
                    SEL_TENTHS:  rd = tenths_q;
                    SEL_SECONDS: rd = sec_q;
                    SEL_MINUTES: rd = min_q;
                    SEL_HOURS:   rd = hour_q;
                    SEL_ICR: begin
                        rd = flags_q;
                        flags_q = '0;
                        irq_q = 1'b0;
                    end
                    default: rd = '0;
                endcase
            end
            OP_WRITE: begin
                writes++;
                if (it.reg_select < SEL_ICR) begin
                    // The counters only hold as many bits as the time needs.
                    keep = (it.reg_select == SEL_TENTHS) ? 8'h0F :
                           (it.reg_select == SEL_HOURS)  ? 8'h9F : 8'h7F;
                    if (it.write_to_alarm) begin
                        alarm_q[it.reg_select[1:0]] = it.write_data & keep;
                    end else begin
                        case (it.reg_select)
                            SEL_TENTHS:  tenths_q = it.write_data & keep;
                            SEL_SECONDS: sec_q    = it.write_data & keep;
                            SEL_MINUTES: min_q    = it.write_data & keep;
                            default:     hour_q   = it.write_data & keep;
                        endcase
                    end
                end else if (it.reg_select == SEL_ICR) begin
                    if (it.write_data[7]) begin
                        mask_q = mask_q | it.write_data[6:0];
                    end else begin
                        mask_q = mask_q & ~it.write_data[6:0];
                    end
                end
            end
            default: ;
        endcase
        res.read_data = rd;
        res.irq = irq_q;
    endtask

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        mismatches++;
        $display("mismatch at %0t: %s is %0h, expected %0h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (!aresetn) begin
            reload_q = PRESCALE_RESET;
            presc_q  = '0;
            tenths_q = '0;
            sec_q    = '0;
            min_q    = '0;
            hour_q   = '0;
            for (int i = 0; i < 4; i++) alarm_q[i] = '0;
            flags_q  = '0;
            mask_q   = '0;
            irq_q    = 1'b0;
            due_outputs.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_RELOAD) begin
                reload_q = pwdata[19:0];
            end
            if (s_valid && s_ready) begin
                apply_tod_item(s_data, want);
                due_outputs.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (due_outputs.size() == 0) begin
                    report("result with nothing outstanding, read_data", m_data.read_data, '0);
                end else begin
                    want = due_outputs.pop_front();
                    if (m_data.read_data !== want.read_data) begin
                        report("read_data", m_data.read_data, want.read_data);
                    end
                    if (m_data.irq !== want.irq) begin
                        report("irq", {7'd0, m_data.irq}, {7'd0, want.irq});
                    end
                end
            end
        end
        fail_count  <= mismatches;
        pending     <= due_outputs.size();
        tick_count  <= ticks;
        read_count  <= reads;
        write_count <= writes;
        alarm_hits  <= hits;
        irq_raises  <= raises;
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

// Top of the testbench for the BCD time-of-day clock. This module only makes
// stimulus and gives the verdict; the checker beside the block predicts every
// result and counts mismatches.
module tb;
    import bcdtod_pkg::*;

    // Codes the package does not name: the spare operation and a spare select.
    localparam logic [1:0] OP_SPARE  = 2'd3;
    localparam logic [2:0] SEL_SPARE = 3'd7;

    localparam logic [PADDR_W-1:0] ADDR_RELOAD = '0;

    // Longest run of cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 1000;
    localparam int ITEMS_PER_PHASE = 250;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count, pending;
    int tick_count, read_count, write_count, alarm_hits, irq_raises;

    // Stimulus bookkeeping. Only items that the block acts on are counted.
    int          sent = 0;
    int          reload_writes = 0;
    int          stall_cycles = 0;
    bit          tx_burst = 1'b0;
    logic [19:0] cur_reload = PRESCALE_RESET;
    logic [19:0] reload_plan [5];

    bcd_tod_clock_alarm_interrupt uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tod_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .pending     (pending),
        .tick_count  (tick_count),
        .read_count  (read_count),
        .write_count (write_count),
        .alarm_hits  (alarm_hits),
        .irq_raises  (irq_raises)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offers one item on the input channel. A random gap comes first unless
    // the sender is in a burst stretch. Valid is only lowered during a gap, so
    // back-to-back items keep it high across the transfer edge. The task
    // returns at the edge where the transfer happens.
    task automatic send(input logic [1:0] op, input logic [2:0] sel, input logic [7:0] data,
                        input logic to_alarm, input logic uf_a, input logic uf_b);
        in_item_t it;
        int gap;
        it.operation         = op;
        it.reg_select        = sel;
        it.write_data        = data;
        it.write_to_alarm    = to_alarm;
        it.timer_a_underflow = uf_a;
        it.timer_b_underflow = uf_b;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // Spare operations and spare selects leave the block untouched.
        if (op == OP_TICK || ((op == OP_READ || op == OP_WRITE) && sel <= SEL_ICR)) begin
            sent++;
        end
    endtask

    // Stops offering items and waits until every predicted result has been
    // transferred. The checker updates its count at the clock edge, so the task
    // waits for an edge before it trusts the count, and it lets further edges
    // pass once the input and result registers of the block have drained.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write of the prescaler reload: setup cycle, then access cycle.
    task automatic write_reload(input logic [19:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_RELOAD;
        pwdata  <= {12'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_reload = value;
        reload_writes++;
    endtask

    // Ticks with an occasional timer underflow. The select and data fields are
    // ignored on a tick, so they carry random bits.
    task automatic run_ticks(input int n);
        repeat (n) begin
            send(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom), 1'b0,
                 $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        end
    endtask

    // Number of ticks that covers the given count of tenths at the present
    // reload, capped so that a large reload does not stall the run.
    function automatic int ticks_for(input int tenths);
        int n;
        n = tenths * (int'(cur_reload) + 1) + $urandom_range(0, 2);
        return (n > 40) ? 40 : n;
    endfunction

    // Sets a valid time, arms the alarm a few tenths ahead, usually enables
    // the alarm interrupt, ticks toward the alarm (past it unless the tick count is capped) and reads the flags back.
    task automatic alarm_run();
        logic [7:0] t_tenths, t_sec, t_min, t_hour;
        int ahead;
        ahead = $urandom_range(1, 3);
        t_tenths = 8'($urandom_range(0, 5));
        t_sec[7:4] = 4'($urandom_range(0, 5));
        t_sec[3:0] = 4'($urandom_range(0, 9));
        t_min[7:4] = 4'($urandom_range(0, 5));
        t_min[3:0] = 4'($urandom_range(0, 9));
        t_hour = '0;
        t_hour[7] = 1'($urandom_range(0, 1));
        t_hour[4] = 1'($urandom_range(0, 1));
        t_hour[3:0] = t_hour[4] ? 4'($urandom_range(0, 1)) : 4'($urandom_range(0, 9));
        send(OP_WRITE, SEL_TENTHS, t_tenths, 1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_SECONDS, t_sec, 1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_MINUTES, t_min, 1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_HOURS, t_hour, 1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_TENTHS, 8'(t_tenths + ahead), 1'b1, 1'b0, 1'b0);
        send(OP_WRITE, SEL_SECONDS, t_sec, 1'b1, 1'b0, 1'b0);
        send(OP_WRITE, SEL_MINUTES, t_min, 1'b1, 1'b0, 1'b0);
        send(OP_WRITE, SEL_HOURS, t_hour, 1'b1, 1'b0, 1'b0);
        if ($urandom_range(0, 3) != 0) begin
            send(OP_WRITE, SEL_ICR, 8'h84, 1'b0, 1'b0, 1'b0);
        end
        run_ticks(ticks_for(ahead + 1));
        send(OP_READ, SEL_ICR, 8'($urandom), 1'b0, 1'b0, 1'b0);
    endtask

    // Puts the time just before a rollover, sometimes with digits that are
    // not valid BCD, ticks toward it and reads the whole time back.
    task automatic rollover_run();
        send(OP_WRITE, SEL_TENTHS, $urandom_range(0, 1) ? 8'h09 : 8'($urandom),
             1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_SECONDS, $urandom_range(0, 1) ? 8'h59 : 8'($urandom),
             1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_MINUTES, $urandom_range(0, 1) ? 8'h59 : 8'($urandom),
             1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_HOURS, 8'($urandom), 1'b0, 1'b0, 1'b0);
        run_ticks(ticks_for($urandom_range(1, 3)));
        send(OP_READ, SEL_TENTHS, 8'($urandom), 1'b0, 1'b0, 1'b0);
        send(OP_READ, SEL_SECONDS, 8'($urandom), 1'b0, 1'b0, 1'b0);
        send(OP_READ, SEL_MINUTES, 8'($urandom), 1'b0, 1'b0, 1'b0);
        send(OP_READ, SEL_HOURS, 8'($urandom), 1'b0, 1'b0, 1'b0);
    endtask

    // One loose item: mostly ticks and register accesses, the rest noise
    // with every field fully random, spare codes included.
    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            run_ticks(1);
        end else if (pick < 55) begin
            send(OP_READ, 3'($urandom_range(0, 4)), 8'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom));
        end else if (pick < 75) begin
            send(OP_WRITE, 3'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom));
        end else if (pick < 85) begin
            send(OP_WRITE, SEL_ICR, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        end else begin
            send(2'($urandom), 3'($urandom), 8'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom));
        end
    endtask

    // Result side: for every result the receiver draws a stall before it
    // raises ready, except in burst stretches where ready stays high.
    initial begin
        int gap;
        bit rx_burst;
        rx_burst = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        end
    end

    // Watchdog: any transfer, APB access or reset restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Main stimulus.
    initial begin
        int target;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        reload_plan[0] = 20'd0;
        reload_plan[1] = 20'd1;
        reload_plan[2] = 20'd3;
        reload_plan[3] = 20'($urandom_range(4, 15));
        reload_plan[4] = 20'hFFFFF;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed part runs with a zero reload, so every tick advances the
        // clock by one tenth.
        write_reload(20'd0);
        // Out-of-range tenths wraps with a carry on the next tick.
        send(OP_WRITE, SEL_TENTHS, 8'hFF, 1'b0, 1'b0, 1'b0);
        send(OP_TICK, SEL_TENTHS, 8'h00, 1'b0, 1'b0, 1'b0);
        send(OP_READ, SEL_TENTHS, 8'h00, 1'b0, 1'b0, 1'b0);
        // 11 PM with non-BCD seconds: everything rolls over to midnight.
        send(OP_WRITE, SEL_SECONDS, 8'hFF, 1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_MINUTES, 8'h59, 1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_HOURS, 8'h91, 1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_TENTHS, 8'h09, 1'b0, 1'b0, 1'b0);
        send(OP_TICK, SEL_HOURS, 8'hFF, 1'b1, 1'b0, 1'b0);
        send(OP_READ, SEL_HOURS, 8'h00, 1'b0, 1'b0, 1'b0);
        // 11:59:59.9 AM turns into 12 PM, which is stored as hour zero with PM.
        send(OP_WRITE, SEL_HOURS, 8'h11, 1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_MINUTES, 8'h59, 1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_SECONDS, 8'h59, 1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_TENTHS, 8'h09, 1'b0, 1'b0, 1'b0);
        send(OP_TICK, SEL_TENTHS, 8'h00, 1'b0, 1'b0, 1'b0);
        send(OP_READ, SEL_HOURS, 8'h00, 1'b0, 1'b0, 1'b0);
        // Alarm one tenth ahead with every mask bit set, plus both timers.
        send(OP_WRITE, SEL_HOURS, 8'h80, 1'b1, 1'b0, 1'b0);
        send(OP_WRITE, SEL_TENTHS, 8'h01, 1'b1, 1'b0, 1'b0);
        send(OP_WRITE, SEL_ICR, 8'hFF, 1'b0, 1'b0, 1'b0);
        send(OP_TICK, SEL_TENTHS, 8'h00, 1'b0, 1'b1, 1'b1);
        send(OP_READ, SEL_ICR, 8'h00, 1'b0, 1'b0, 1'b0);
        // Spare select and spare operation change nothing.
        send(OP_READ, SEL_SPARE, 8'h00, 1'b0, 1'b0, 1'b0);
        send(OP_WRITE, SEL_SPARE, 8'hFF, 1'b1, 1'b0, 1'b0);
        send(OP_SPARE, SEL_ICR, 8'hFF, 1'b1, 1'b1, 1'b1);
        // Clearing the whole mask keeps a timer flag from raising the line.
        send(OP_WRITE, SEL_ICR, 8'h7F, 1'b0, 1'b0, 1'b0);
        send(OP_TICK, SEL_TENTHS, 8'h00, 1'b0, 1'b1, 1'b0);
        send(OP_READ, SEL_ICR, 8'h00, 1'b0, 1'b0, 1'b0);

        // Random phases, one per reload setting. Each change of the reload
        // happens with the block drained, which also gives the receiver a
        // stretch where the sender holds back completely.
        for (int p = 0; p < 5; p++) begin
            wait_idle();
            write_reload(reload_plan[p]);
            target = sent + ITEMS_PER_PHASE;
            while (sent < target) begin
                if ($urandom_range(0, 9) == 0) tx_burst = !tx_burst;
                case ($urandom_range(0, 9))
                    0, 1, 2: alarm_run();
                    3, 4:    rollover_run();
                    default: repeat (8) random_item();
                endcase
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        $display("Sent %0d ticks, %0d reads and %0d writes across %0d prescaler reloads.",
                 tick_count, read_count, write_count, reload_writes);
        $display("The alarm matched on %0d ticks and the interrupt line rose %0d times.",
                 alarm_hits, irq_raises);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
